FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property holds at every edge outside reset
`define DCF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Antecedent in one cycle implies consequent in the next
`define DCF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define DCF_ASSERT(lbl, clk, rst_n, prop)
`define DCF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/dcf_pkg.sv
// ----------------------------------------------------------------------------
// dcf_pkg
// Shared types and constants of the delimited chunk framer.
// ----------------------------------------------------------------------------
package dcf_pkg;

  // Configuration port address width and register indexes
  localparam int CFG_ADDR_W = 4;

  localparam logic [1:0] REG_START_SEQ = 2'd0;
  localparam logic [1:0] REG_END_SEQ   = 2'd1;
  localparam logic [1:0] REG_PAD_BYTE  = 2'd2;

  // One input item
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       frame_end;
    logic       empty_frame;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       chunk_last;
    logic       frame_last;
    logic       run_last;
  } out_item_t;

  // Register file contents seen by the emitter
  typedef struct packed {
    logic [31:0] start_sequence;
    logic [31:0] end_sequence;
    logic [7:0]  pad_byte;
  } cfg_t;

endpackage

FILE: rtl/delimited_chunk_framer_top.sv
// ----------------------------------------------------------------------------
// delimited_chunk_framer_top
// Frames payload bytes with start/end delimiters into fixed-size chunks.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one payload byte per transfer with its
//   frame_end and empty_frame flags. out_valid/out_ready/out_data carry the
//   framed byte stream with chunk_last, frame_last and run_last markers.
//   The APB-style port (psel .. pready) holds start_sequence (0x0),
//   end_sequence (0x4) and pad_byte (0x8); write them while the block idles.
//   Each input transfer yields one byte per cycle while out_ready is high: 1
//   for a mid-frame byte, plus SEQ_BYTES for a frame opening, plus SEQ_BYTES
//   and the padding up to the chunk boundary for a frame close. in_ready is
//   dropped while the sequencer emits the extra bytes, so throughput is one
//   payload byte per cycle inside a frame while out_ready is high. An input
//   transfer reaches the output through the item register, then the result
//   register. Reset clears the open-frame flag, chunk position and both valid
//   stages; configuration registers return to zero. When out_ready is low
//   the result register holds, the sequencer stalls and one further item may
//   wait in the item register.
// ----------------------------------------------------------------------------
module delimited_chunk_framer_top #(
  parameter int SEQ_BYTES   = 4,
  parameter int CHUNK_BYTES = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  dcf_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output dcf_pkg::out_item_t             out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dcf_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  dcf_pkg::cfg_t      cfg;
  logic               emit_valid;
  logic               emit_ready;
  dcf_pkg::out_item_t emit_data;

  // Register file
  dcf_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Byte sequencer
  dcf_emitter #(
    .SEQ_BYTES   (SEQ_BYTES),
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .cfg        (cfg),
    .emit_valid (emit_valid),
    .emit_ready (emit_ready),
    .emit_data  (emit_data)
  );

  // Result register
  dcf_out_reg u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (emit_valid),
    .s_ready (emit_ready),
    .s_data  (emit_data),
    .m_valid (out_valid),
    .m_ready (out_ready),
    .m_data  (out_data)
  );

endmodule

FILE: rtl/dcf_cfg_regs.sv
// ----------------------------------------------------------------------------
// dcf_cfg_regs
// APB-style register file: start sequence, end sequence and pad byte.
// ----------------------------------------------------------------------------
module dcf_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dcf_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output dcf_pkg::cfg_t                cfg
);

  dcf_pkg::cfg_t cfg_r;
  logic          wr_en;
  logic [1:0]    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  // Register writes; unmapped index is ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        dcf_pkg::REG_START_SEQ: cfg_r.start_sequence <= pwdata;
        dcf_pkg::REG_END_SEQ:   cfg_r.end_sequence   <= pwdata;
        dcf_pkg::REG_PAD_BYTE:  cfg_r.pad_byte       <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      dcf_pkg::REG_START_SEQ: prdata = cfg_r.start_sequence;
      dcf_pkg::REG_END_SEQ:   prdata = cfg_r.end_sequence;
      dcf_pkg::REG_PAD_BYTE:  prdata = {24'd0, cfg_r.pad_byte};
      default:                prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/dcf_emitter.sv
// ----------------------------------------------------------------------------
// dcf_emitter
// Item register plus byte sequencer: start sequence, payload, end sequence
// and chunk padding, one byte per cycle while emit_ready is high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dcf_emitter #(
  parameter int SEQ_BYTES   = 4,
  parameter int CHUNK_BYTES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  dcf_pkg::in_item_t  in_data,
  input  dcf_pkg::cfg_t      cfg,
  output logic               emit_valid,
  input  logic               emit_ready,
  output dcf_pkg::out_item_t emit_data
);

  localparam int SEQ_W  = (SEQ_BYTES > 1) ? $clog2(SEQ_BYTES) : 1;
  localparam int CPOS_W = $clog2(CHUNK_BYTES);
  localparam logic [SEQ_W-1:0]  SEQ_LAST   = SEQ_W'(SEQ_BYTES - 1);
  localparam logic [CPOS_W-1:0] CHUNK_LAST = CPOS_W'(CHUNK_BYTES - 1);

  // Sequencer phases
  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_DATA  = 2'd1;
  localparam logic [1:0] PH_END   = 2'd2;
  localparam logic [1:0] PH_PAD   = 2'd3;

  dcf_pkg::in_item_t  item_r;
  logic               item_valid_r, item_valid_nxt;
  logic [1:0]         phase_r, phase_nxt;
  logic [SEQ_W-1:0]   idx_r, idx_nxt;
  logic               in_frame_r, in_frame_nxt;
  logic [CPOS_W-1:0]  chunk_pos_r, chunk_pos_nxt;

  logic               fire;
  logic               done_fire;
  logic               item_done;
  logic               seq_done;
  logic               chunk_end;
  logic               in_accept;
  logic [7:0]         byte_sel;

  // Delimiter byte: idx 0 is the most significant used byte
  function automatic logic [7:0] delim_sel(input logic [31:0] seq,
                                           input logic [SEQ_W-1:0] idx);
    logic [SEQ_W-1:0] pos;
    logic [3:0]       pos_ext;
    pos     = SEQ_LAST - idx;
    pos_ext = 4'(pos);
    if (pos_ext < 4'd4) begin
      delim_sel = seq[{pos_ext[1:0], 3'b000} +: 8];
    end else begin
      delim_sel = 8'd0;
    end
  endfunction

  assign seq_done  = (idx_r == SEQ_LAST);
  assign chunk_end = (chunk_pos_r == CHUNK_LAST);

  // Byte for the current phase and whether the item finishes with it
  always_comb begin
    unique case (phase_r)
      PH_START: begin
        byte_sel  = delim_sel(cfg.start_sequence, idx_r);
        item_done = 1'b0;
      end
      PH_DATA: begin
        byte_sel  = item_r.payload_byte;
        item_done = ~item_r.frame_end;
      end
      PH_END: begin
        byte_sel  = delim_sel(cfg.end_sequence, idx_r);
        item_done = 1'b0;
      end
      default: begin
        byte_sel  = cfg.pad_byte;
        item_done = chunk_end;
      end
    endcase
  end

  assign emit_valid           = item_valid_r;
  assign emit_data.out_byte   = byte_sel;
  assign emit_data.chunk_last = chunk_end;
  assign emit_data.frame_last = item_done & (phase_r == PH_PAD);
  assign emit_data.run_last   = item_done;

  assign fire      = item_valid_r & emit_ready;
  assign done_fire = fire & item_done;
  assign in_ready  = ~item_valid_r | done_fire;
  assign in_accept = in_valid & in_ready;

  // Frame state, chunk position and item slot
  always_comb begin
    in_frame_nxt   = done_fire ? (phase_r == PH_DATA) : in_frame_r;
    chunk_pos_nxt  = chunk_pos_r;
    if (fire) begin
      chunk_pos_nxt = chunk_end ? '0 : chunk_pos_r + 1'b1;
    end
    item_valid_nxt = in_accept ? 1'b1 : (done_fire ? 1'b0 : item_valid_r);
  end

  // Phase sequencing; a newly loaded item picks its first phase
  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    if (fire) begin
      unique case (phase_r)
        PH_START: begin
          if (seq_done) begin
            idx_nxt   = '0;
            phase_nxt = item_r.empty_frame ? PH_END : PH_DATA;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
        PH_DATA: begin
          idx_nxt   = '0;
          phase_nxt = PH_END;
        end
        PH_END: begin
          if (seq_done) begin
            phase_nxt = PH_PAD;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (in_accept) begin
      idx_nxt = '0;
      if (!in_frame_nxt) begin
        phase_nxt = PH_START;
      end else if (in_data.empty_frame) begin
        phase_nxt = PH_END;
      end else begin
        phase_nxt = PH_DATA;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      phase_r      <= PH_START;
      idx_r        <= '0;
      in_frame_r   <= 1'b0;
      chunk_pos_r  <= '0;
    end else begin
      item_valid_r <= item_valid_nxt;
      phase_r      <= phase_nxt;
      idx_r        <= idx_nxt;
      in_frame_r   <= in_frame_nxt;
      chunk_pos_r  <= chunk_pos_nxt;
    end
  end

  // Item payload register
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r <= in_data;
    end
  end

  // Checks
  `DCF_ASSERT(a_pos_range, clk, rst_n, chunk_pos_r <= CHUNK_LAST)
  `DCF_ASSERT(a_start_closed, clk, rst_n,
    (item_valid_r && phase_r == PH_START) |-> !in_frame_r)
  `DCF_ASSERT(a_data_not_empty, clk, rst_n,
    (item_valid_r && phase_r == PH_DATA) |-> !item_r.empty_frame)
  `DCF_ASSERT_NEXT(a_close_aligned, clk, rst_n, fire && emit_data.frame_last,
    !in_frame_r && chunk_pos_r == '0)

endmodule

FILE: rtl/dcf_out_reg.sv
// ----------------------------------------------------------------------------
// dcf_out_reg
// Result register between the sequencer and the output channel.
// ----------------------------------------------------------------------------
module dcf_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               s_valid,
  output logic               s_ready,
  input  dcf_pkg::out_item_t s_data,
  output logic               m_valid,
  input  logic               m_ready,
  output dcf_pkg::out_item_t m_data
);

  logic               valid_r, valid_nxt;
  dcf_pkg::out_item_t data_r;

  // Load whenever empty or the held result is being taken
  assign s_ready   = ~valid_r | m_ready;
  assign valid_nxt = s_ready ? s_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      data_r <= s_data;
    end
  end

  assign m_valid = valid_r;
  assign m_data  = data_r;

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the delimited chunk framer. A table of directed
// items and register writes comes first, then random frames under three
// idling mixes. Every output transfer is compared field by field against a
// predictor that models the start/end delimiters, chunk padding and flags.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int SEQ_BYTES   = 4;
  localparam int CHUNK_BYTES = 16;
  localparam int CYCLE_LIMIT = 400_000;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_SLACK = 8;
  localparam int NUM_ROWS    = 30;

  // Address with no register behind it; writes there must be ignored
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef enum logic [1:0] {ROW_ITEM, ROW_CFG} row_kind_t;

  // One directed step: an input item (with an optional typed expectation)
  // or a register write
  typedef struct {
    row_kind_t          kind;
    dcf_pkg::in_item_t  item;
    int                 exp_len;
    logic [7:0]         exp_fill;
    logic [1:0]         reg_idx;
    logic [31:0]        value;
  } stim_row_t;

  logic               clk     = 1'b0;
  logic               rst_n   = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  dcf_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  dcf_pkg::out_item_t out_data;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [dcf_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata  = '0;
  logic [31:0]        prdata;
  logic               pready;

  // Predictor state and its copy of the registers
  logic        frame_open;
  int          chunk_fill;
  logic [31:0] cur_start;
  logic [31:0] cur_end;
  logic [7:0]  cur_pad;

  dcf_pkg::out_item_t run_bytes[$];
  dcf_pkg::out_item_t framed_bytes_due[$];

  int          mismatches;
  int          results_seen;
  int          cycle_count;
  int          snd_idle;
  int          rcv_idle;
  int          hold_kick;
  int          hold_seen;
  int          hold_left;

  stim_row_t   directed_rows [NUM_ROWS];

  delimited_chunk_framer_top #(
    .SEQ_BYTES  (SEQ_BYTES),
    .CHUNK_BYTES(CHUNK_BYTES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  // Delimiter byte k, k = 0 sent first; bytes above bit 31 read as zero
  function automatic logic [7:0] seq_byte(logic [31:0] seq, int k);
    int sh;
    sh = 8 * (SEQ_BYTES - 1 - k);
    if (sh >= 32) return 8'h00;
    return 8'(seq >> sh);
  endfunction

  function automatic void put_out_byte(logic [7:0] b);
    dcf_pkg::out_item_t r;
    chunk_fill = (chunk_fill + 1) % CHUNK_BYTES;
    r = '{out_byte: b, chunk_last: (chunk_fill == 0), frame_last: 1'b0, run_last: 1'b0};
    run_bytes.push_back(r);
  endfunction

  // Works out the bytes one accepted item causes and queues them
  function automatic void predict_framing(dcf_pkg::in_item_t it);
    run_bytes.delete();
    if (!frame_open) begin
      for (int k = 0; k < SEQ_BYTES; k++) put_out_byte(seq_byte(cur_start, k));
      frame_open = 1'b1;
    end
    if (!it.empty_frame) put_out_byte(it.payload_byte);
    if (it.empty_frame || it.frame_end) begin
      for (int k = 0; k < SEQ_BYTES; k++) put_out_byte(seq_byte(cur_end, k));
      do put_out_byte(cur_pad); while (chunk_fill != 0);
      run_bytes[run_bytes.size() - 1].frame_last = 1'b1;
      frame_open = 1'b0;
      chunk_fill = 0;
    end
    run_bytes[run_bytes.size() - 1].run_last = 1'b1;
    foreach (run_bytes[i]) framed_bytes_due.push_back(run_bytes[i]);
  endfunction

  function automatic stim_row_t item_row(logic [7:0] b, logic fe, logic ef,
                                         int exp_len, logic [7:0] exp_fill);
    stim_row_t r;
    r.kind     = ROW_ITEM;
    r.item     = '{payload_byte: b, frame_end: fe, empty_frame: ef};
    r.exp_len  = exp_len;
    r.exp_fill = exp_fill;
    r.reg_idx  = dcf_pkg::REG_START_SEQ;
    r.value    = '0;
    return r;
  endfunction

  function automatic stim_row_t reg_row(logic [1:0] idx, logic [31:0] value);
    stim_row_t r;
    r.kind     = ROW_CFG;
    r.item     = '0;
    r.exp_len  = 0;
    r.exp_fill = 8'h00;
    r.reg_idx  = idx;
    r.value    = value;
    return r;
  endfunction

  // Result side: check each transfer, then choose ready for the next cycle
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (framed_bytes_due.size() == 0) begin
        note_mismatch($sformatf("result %0d: unexpected byte %02h", results_seen,
                                out_data.out_byte));
      end else begin
        dcf_pkg::out_item_t want;
        want = framed_bytes_due.pop_front();
        if (out_data.out_byte !== want.out_byte || out_data.chunk_last !== want.chunk_last ||
            out_data.frame_last !== want.frame_last ||
            out_data.run_last !== want.run_last)
          note_mismatch($sformatf(
            "result %0d: expected %02h c%b f%b r%b, got %02h c%b f%b r%b", results_seen,
            want.out_byte, want.chunk_last, want.frame_last, want.run_last,
            out_data.out_byte, out_data.chunk_last, out_data.frame_last,
            out_data.run_last));
      end
      results_seen++;
    end
    if (hold_kick != hold_seen) begin
      hold_seen = hold_kick;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rcv_idle);
    end
  end

  // Offer one item, idling at random first; returns at the accepting edge
  task automatic offer_byte(dcf_pkg::in_item_t it);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    predict_framing(it);
  endtask

  // Stop offering and wait for every outstanding byte
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (framed_bytes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the register takes the value at pready
  task automatic cfg_write(logic [1:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= dcf_pkg::CFG_ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      dcf_pkg::REG_START_SEQ: cur_start = value;
      dcf_pkg::REG_END_SEQ:   cur_end   = value;
      dcf_pkg::REG_PAD_BYTE:  cur_pad   = value[7:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_config(logic [31:0] start_word, logic [31:0] end_word,
                             logic [7:0] pad_value);
    wait_drained();
    cfg_write(dcf_pkg::REG_START_SEQ, start_word);
    cfg_write(dcf_pkg::REG_END_SEQ, end_word);
    cfg_write(dcf_pkg::REG_PAD_BYTE, {24'h0, pad_value});
  endtask

  // Mostly whole frames with random content; some empty, broken or left open
  task automatic run_random(int n_items);
    int                sent;
    int                len;
    int                kind;
    int                pause_at;
    dcf_pkg::in_item_t it;
    sent     = 0;
    pause_at = 15;
    while (sent < n_items) begin
      kind = $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0) len = $urandom_range(0, 1) ? 8 : 24;
      else len = $urandom_range(1, 20);
      if (kind == 0) begin
        it = '{payload_byte: 8'($urandom_range(0, 255)),
               frame_end: 1'($urandom_range(0, 1)), empty_frame: 1'b1};
        offer_byte(it);
        sent++;
      end else begin
        for (int i = 0; i < len; i++) begin
          it.payload_byte = 8'($urandom_range(0, 255));
          it.empty_frame  = 1'b0;
          it.frame_end    = (kind >= 3) && (i == len - 1);
          offer_byte(it);
          sent++;
        end
        // broken frame: closed by an empty item instead of a frame end
        if (kind == 1) begin
          it = '{payload_byte: 8'($urandom_range(0, 255)),
                 frame_end: 1'($urandom_range(0, 1)), empty_frame: 1'b1};
          offer_byte(it);
          sent++;
        end
      end
      if (sent >= pause_at) begin
        wait_drained();
        pause_at = sent + 15;
      end
    end
  endtask

  initial begin
    frame_open   = 1'b0;
    chunk_fill   = 0;
    cur_start    = '0;
    cur_end      = '0;
    cur_pad      = '0;
    mismatches   = 0;
    results_seen = 0;
    cycle_count  = 0;
    hold_kick    = 0;
    hold_seen    = 0;
    hold_left    = 0;
    snd_idle     = 12;
    rcv_idle     = 56;

    directed_rows = '{
      // reset values: all delimiter and pad bytes zero
      item_row(8'h00, 1'b0, 1'b0, 5, 8'h00),
      item_row(8'h00, 1'b0, 1'b0, 1, 8'h00),
      item_row(8'h00, 1'b1, 1'b0, 10, 8'h00),
      item_row(8'h00, 1'b0, 1'b1, 16, 8'h00),
      // all-ones registers and payload
      reg_row(dcf_pkg::REG_START_SEQ, 32'hFFFF_FFFF),
      reg_row(dcf_pkg::REG_END_SEQ, 32'hFFFF_FFFF),
      reg_row(dcf_pkg::REG_PAD_BYTE, 32'h0000_00FF),
      item_row(8'hFF, 1'b1, 1'b0, 16, 8'hFF),
      item_row(8'hFF, 1'b0, 1'b1, 16, 8'hFF),
      // empty frame and frame end together count as an empty frame
      item_row(8'hFF, 1'b1, 1'b1, 16, 8'hFF),
      reg_row(dcf_pkg::REG_START_SEQ, 32'hA1B2_C3D4),
      reg_row(dcf_pkg::REG_END_SEQ, 32'h5E6F_7081),
      reg_row(dcf_pkg::REG_PAD_BYTE, 32'h0000_003C),
      // eight bytes plus both delimiters fill a chunk exactly: extra pad chunk
      item_row(8'h12, 1'b0, 1'b0, 0, 8'h00),
      item_row(8'h34, 1'b0, 1'b0, 0, 8'h00),
      item_row(8'h56, 1'b0, 1'b0, 0, 8'h00),
      item_row(8'h78, 1'b0, 1'b0, 0, 8'h00),
      item_row(8'h9A, 1'b0, 1'b0, 0, 8'h00),
      item_row(8'hBC, 1'b0, 1'b0, 0, 8'h00),
      item_row(8'hDE, 1'b0, 1'b0, 0, 8'h00),
      item_row(8'hF0, 1'b1, 1'b0, 0, 8'h00),
      // empty item closes an open frame without a payload byte
      item_row(8'h55, 1'b0, 1'b0, 0, 8'h00),
      item_row(8'hAA, 1'b0, 1'b0, 0, 8'h00),
      item_row(8'h00, 1'b0, 1'b1, 0, 8'h00),
      item_row(8'hC3, 1'b0, 1'b1, 0, 8'h00),
      reg_row(REG_UNUSED, 32'h0000_0077),
      // registers rewritten while a frame is open
      item_row(8'h0F, 1'b0, 1'b0, 0, 8'h00),
      reg_row(dcf_pkg::REG_PAD_BYTE, 32'h0000_0081),
      reg_row(dcf_pkg::REG_END_SEQ, 32'h00FF_00FF),
      item_row(8'hF0, 1'b1, 1'b0, 0, 8'h00)
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        wait_drained();
        cfg_write(directed_rows[i].reg_idx, directed_rows[i].value);
      end else begin
        offer_byte(directed_rows[i].item);
        if (directed_rows[i].exp_len != 0) begin
          if (run_bytes.size() != directed_rows[i].exp_len)
            note_mismatch($sformatf("row %0d: expected %0d bytes, predicted %0d", i,
                                    directed_rows[i].exp_len, run_bytes.size()));
          foreach (run_bytes[j])
            if (run_bytes[j].out_byte !== directed_rows[i].exp_fill)
              note_mismatch($sformatf("row %0d byte %0d: expected %02h, predicted %02h",
                                      i, j, directed_rows[i].exp_fill,
                                      run_bytes[j].out_byte));
        end
      end
    end

    // Random: light sender idling, heavy receiver idling, one long hold-off
    load_config($urandom, $urandom, 8'($urandom_range(0, 255)));
    hold_kick++;
    run_random(25);

    // Heavy sender idling, light receiver idling
    load_config(32'h0000_0000, 32'hFFFF_FFFF, 8'h00);
    snd_idle = 56;
    rcv_idle = 12;
    run_random(25);

    // Full rate both sides, apart from a second hold-off
    load_config($urandom, $urandom, 8'($urandom_range(0, 255)));
    snd_idle = 0;
    rcv_idle = 0;
    hold_kick++;
    run_random(20);

    wait_drained();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: delimited_chunk_framer_top.f
+incdir+rtl
rtl/dcf_pkg.sv
rtl/dcf_cfg_regs.sv
rtl/dcf_emitter.sv
rtl/dcf_out_reg.sv
rtl/delimited_chunk_framer_top.sv
bench/tb_top.sv
